[hdl/bqwm_pkg.sv]
// ----------------------------------------------------------------------------
// bqwm_pkg
// Shared types, register codes and the microcode program of the biquad
// filter with wet mix.
// ----------------------------------------------------------------------------
package bqwm_pkg;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic        [2:0]  channel_in;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic        [2:0]  channel_out;
  } out_word_t;

  typedef struct packed {
    logic signed [23:0] a0;
    logic signed [23:0] a1;
    logic signed [23:0] a2;
    logic signed [23:0] b1;
    logic signed [23:0] b2;
    logic        [15:0] wet;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_A0  = 3'd0,
    CFG_A1  = 3'd1,
    CFG_A2  = 3'd2,
    CFG_B1  = 3'd3,
    CFG_B2  = 3'd4,
    CFG_WET = 3'd5
  } cfg_idx_e;

  localparam logic signed [23:0] A0_RESET  = 24'sd262144;
  localparam logic        [15:0] WET_RESET = 16'd32768;

  typedef enum logic [2:0] {
    MA_A0, MA_A1, MA_A2, MA_B1, MA_B2, MA_WET
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_X, MB_X1, MB_X2, MB_Y1, MB_Y2, MB_DIFF
  } mul_b_e;

  typedef enum logic [1:0] {
    ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    OUT_NONE, OUT_MIX, OUT_PASS
  } out_op_e;

  typedef enum logic [1:0] {
    J_NONE, J_NO_START, J_BYPASS, J_OUT_BUSY
  } jmp_e;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_A0   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_A1   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_A2   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_B1   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_B2   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd6;
  localparam logic [STEP_W-1:0] STEP_Y    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_WET  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_MIX  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_PASS = 4'd10;

  typedef struct packed {
    mul_a_e            mul_a;
    mul_b_e            mul_b;
    logic              mul_en;
    acc_op_e           acc_op;
    logic              y_en;
    out_op_e           out_op;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
    logic              ret;
  } ucode_t;

  typedef struct packed {
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    logic    mul_en;
    acc_op_e acc_op;
    logic    y_en;
    out_op_e out_op;
    logic    out_we;
    logic    idle;
  } ctrl_t;

  localparam ucode_t UC_NOP = '{
    mul_a:  MA_A0,
    mul_b:  MB_X,
    mul_en: 1'b0,
    acc_op: ACC_NOP,
    y_en:   1'b0,
    out_op: OUT_NONE,
    jmp:    J_NONE,
    target: STEP_IDLE,
    ret:    1'b0
  };

  function automatic ucode_t ucode(logic [STEP_W-1:0] step);
    ucode_t w;
    w = UC_NOP;
    case (step)
      STEP_IDLE: begin
        w.jmp    = J_NO_START;
        w.target = STEP_IDLE;
      end
      STEP_A0: begin
        w.mul_a  = MA_A0;
        w.mul_b  = MB_X;
        w.mul_en = 1'b1;
        w.jmp    = J_BYPASS;
        w.target = STEP_PASS;
      end
      STEP_A1: begin
        w.mul_a  = MA_A1;
        w.mul_b  = MB_X1;
        w.mul_en = 1'b1;
        w.acc_op = ACC_LOAD;
      end
      STEP_A2: begin
        w.mul_a  = MA_A2;
        w.mul_b  = MB_X2;
        w.mul_en = 1'b1;
        w.acc_op = ACC_ADD;
      end
      STEP_B1: begin
        w.mul_a  = MA_B1;
        w.mul_b  = MB_Y1;
        w.mul_en = 1'b1;
        w.acc_op = ACC_ADD;
      end
      STEP_B2: begin
        w.mul_a  = MA_B2;
        w.mul_b  = MB_Y2;
        w.mul_en = 1'b1;
        w.acc_op = ACC_SUB;
      end
      STEP_LAST: begin
        w.acc_op = ACC_SUB;
      end
      STEP_Y: begin
        w.y_en = 1'b1;
      end
      STEP_WET: begin
        w.mul_a  = MA_WET;
        w.mul_b  = MB_DIFF;
        w.mul_en = 1'b1;
      end
      STEP_MIX: begin
        w.out_op = OUT_MIX;
        w.jmp    = J_OUT_BUSY;
        w.target = STEP_MIX;
        w.ret    = 1'b1;
      end
      STEP_PASS: begin
        w.out_op = OUT_PASS;
        w.jmp    = J_OUT_BUSY;
        w.target = STEP_PASS;
        w.ret    = 1'b1;
      end
      default: begin
        w.ret = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[hdl/bqwm_cfg.sv]
// ----------------------------------------------------------------------------
// bqwm_cfg
// APB register bank holding the filter coefficients and the wet fraction.
// ----------------------------------------------------------------------------
module bqwm_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bqwm_pkg::cfg_t      cfg_o
);

  bqwm_pkg::cfg_t     cfg_q;
  bqwm_pkg::cfg_t     cfg_d;
  bqwm_pkg::cfg_idx_e idx;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = bqwm_pkg::cfg_idx_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        bqwm_pkg::CFG_A0:  cfg_d.a0  = pwdata[23:0];
        bqwm_pkg::CFG_A1:  cfg_d.a1  = pwdata[23:0];
        bqwm_pkg::CFG_A2:  cfg_d.a2  = pwdata[23:0];
        bqwm_pkg::CFG_B1:  cfg_d.b1  = pwdata[23:0];
        bqwm_pkg::CFG_B2:  cfg_d.b2  = pwdata[23:0];
        bqwm_pkg::CFG_WET: cfg_d.wet = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a0  <= bqwm_pkg::A0_RESET;
      cfg_q.a1  <= '0;
      cfg_q.a2  <= '0;
      cfg_q.b1  <= '0;
      cfg_q.b2  <= '0;
      cfg_q.wet <= bqwm_pkg::WET_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      bqwm_pkg::CFG_A0:  prdata = {8'd0, cfg_q.a0};
      bqwm_pkg::CFG_A1:  prdata = {8'd0, cfg_q.a1};
      bqwm_pkg::CFG_A2:  prdata = {8'd0, cfg_q.a2};
      bqwm_pkg::CFG_B1:  prdata = {8'd0, cfg_q.b1};
      bqwm_pkg::CFG_B2:  prdata = {8'd0, cfg_q.b2};
      bqwm_pkg::CFG_WET: prdata = {16'd0, cfg_q.wet};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/bqwm_seq.sv]
// ----------------------------------------------------------------------------
// bqwm_seq
// Microcode sequencer: step counter, program table and conditional jumps.
// ----------------------------------------------------------------------------
module bqwm_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            bypass_i,
  input  logic            out_busy_i,
  output bqwm_pkg::ctrl_t ctrl_o
);

  logic [bqwm_pkg::STEP_W-1:0] step_q;
  logic [bqwm_pkg::STEP_W-1:0] step_d;
  bqwm_pkg::ucode_t            word;
  logic                        taken;

  assign word = bqwm_pkg::ucode(step_q);

  always_comb begin
    case (word.jmp)
      bqwm_pkg::J_NO_START: taken = !start_i;
      bqwm_pkg::J_BYPASS:   taken = bypass_i;
      bqwm_pkg::J_OUT_BUSY: taken = out_busy_i;
      default:              taken = 1'b0;
    endcase
    if (taken) begin
      step_d = word.target;
    end else if (word.ret) begin
      step_d = bqwm_pkg::STEP_IDLE;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= bqwm_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    ctrl_o.mul_a  = word.mul_a;
    ctrl_o.mul_b  = word.mul_b;
    ctrl_o.mul_en = word.mul_en;
    ctrl_o.acc_op = word.acc_op;
    ctrl_o.y_en   = word.y_en;
    ctrl_o.out_op = word.out_op;
    ctrl_o.out_we = (word.out_op != bqwm_pkg::OUT_NONE) && !taken;
    ctrl_o.idle   = (step_q == bqwm_pkg::STEP_IDLE);
  end

endmodule

[hdl/bqwm_datapath.sv]
// ----------------------------------------------------------------------------
// bqwm_datapath
// Shared multiplier, accumulator, rounding and saturation, output sample.
// ----------------------------------------------------------------------------
module bqwm_datapath (
  input  logic               clk_i,
  input  bqwm_pkg::ctrl_t    ctrl_i,
  input  bqwm_pkg::cfg_t     cfg_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] x1_i,
  input  logic signed [15:0] x2_i,
  input  logic signed [15:0] y1_i,
  input  logic signed [15:0] y2_i,
  output logic signed [15:0] y_o,
  output logic signed [15:0] sample_o
);

  logic signed [23:0] a_op;
  logic signed [16:0] b_op;
  logic signed [40:0] mul_w;
  logic signed [40:0] prod_q;
  logic signed [42:0] acc_q;
  logic signed [42:0] acc_d;
  logic signed [15:0] y_q;
  logic signed [15:0] y_w;
  logic signed [16:0] diff_w;
  logic signed [47:0] mix_w;
  logic signed [15:0] sample_q;

  assign diff_w = 17'(y_q) - 17'(x_i);

  always_comb begin
    case (ctrl_i.mul_a)
      bqwm_pkg::MA_A0:  a_op = cfg_i.a0;
      bqwm_pkg::MA_A1:  a_op = cfg_i.a1;
      bqwm_pkg::MA_A2:  a_op = cfg_i.a2;
      bqwm_pkg::MA_B1:  a_op = cfg_i.b1;
      bqwm_pkg::MA_B2:  a_op = cfg_i.b2;
      bqwm_pkg::MA_WET: a_op = {8'd0, cfg_i.wet};
      default:          a_op = '0;
    endcase
    case (ctrl_i.mul_b)
      bqwm_pkg::MB_X:    b_op = 17'(x_i);
      bqwm_pkg::MB_X1:   b_op = 17'(x1_i);
      bqwm_pkg::MB_X2:   b_op = 17'(x2_i);
      bqwm_pkg::MB_Y1:   b_op = 17'(y1_i);
      bqwm_pkg::MB_Y2:   b_op = 17'(y2_i);
      bqwm_pkg::MB_DIFF: b_op = diff_w;
      default:           b_op = '0;
    endcase
  end

  assign mul_w = 41'(a_op) * 41'(b_op);

  always_comb begin
    case (ctrl_i.acc_op)
      bqwm_pkg::ACC_LOAD: acc_d = 43'(prod_q);
      bqwm_pkg::ACC_ADD:  acc_d = acc_q + 43'(prod_q);
      bqwm_pkg::ACC_SUB:  acc_d = acc_q - 43'(prod_q);
      default:            acc_d = acc_q;
    endcase
  end

  assign y_w   = bqwm_pkg::sat16(48'((acc_q + 43'sd131072) >>> 18));
  assign mix_w = 48'(x_i) + ((48'(prod_q) + 48'sd16384) >>> 15);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mul_w;
    end
    acc_q <= acc_d;
    if (ctrl_i.y_en) begin
      y_q <= y_w;
    end
    if (ctrl_i.out_we) begin
      if (ctrl_i.out_op == bqwm_pkg::OUT_MIX) begin
        sample_q <= bqwm_pkg::sat16(mix_w);
      end else begin
        sample_q <= x_i;
      end
    end
  end

  assign y_o      = y_w;
  assign sample_o = sample_q;

endmodule

[hdl/biquad_filter_wet_mix_top.sv]
// ----------------------------------------------------------------------------
// biquad_filter_wet_mix_top
// Multichannel direct form I biquad with dry/wet blend, APB configured.
// ----------------------------------------------------------------------------
// A word is accepted only when the sequencer is idle, so a filtered word runs
// its steps on the single shared 24x17 multiplier before the next word: five
// coefficient product steps, a0-a2 products added into and b1, b2 products
// subtracted from the accumulator in the step after, one step to close the
// sum, one to round and store y, one wet-mix product step, one output step
// and the idle step. A word on a channel at or beyond CHANNELS passes through
// unchanged. The finished word waits in an output register; the sequencer
// holds on its last step while that register is full and out_ready_i is low.
// Reset clears all channel history and sets coefficients to pass-through.
module biquad_filter_wet_mix_top #(
  parameter int CHANNELS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bqwm_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bqwm_pkg::out_word_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W = (CH_W > 3) ? CH_W : 3;

  bqwm_pkg::cfg_t     cfg;
  bqwm_pkg::ctrl_t    ctrl;

  logic signed [15:0] x_q;
  logic [2:0]         ch_q;
  logic               bypass_q;
  logic [2:0]         out_ch_q;
  logic               out_valid_q;
  logic               out_busy;
  logic               accept;
  logic               in_range;
  logic [EXT_W-1:0]   ch_ext;
  logic [CH_W-1:0]    idx;
  logic signed [15:0] y_w;
  logic signed [15:0] sample_w;

  logic signed [15:0] hx1_q [CHANNELS];
  logic signed [15:0] hx2_q [CHANNELS];
  logic signed [15:0] hy1_q [CHANNELS];
  logic signed [15:0] hy2_q [CHANNELS];

  assign in_ready_o = ctrl.idle;
  assign accept     = in_valid_i & ctrl.idle;
  assign out_busy   = out_valid_q & !out_ready_i;
  assign ch_ext     = EXT_W'(ch_q);
  assign in_range   = (32'(ch_q) < CHANNELS);
  assign idx        = in_range ? ch_ext[CH_W-1:0] : '0;

  bqwm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bqwm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i),
    .bypass_i   (bypass_q),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  bqwm_datapath u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg),
    .x_i      (x_q),
    .x1_i     (hx1_q[idx]),
    .x2_i     (hx2_q[idx]),
    .y1_i     (hy1_q[idx]),
    .y2_i     (hy2_q[idx]),
    .y_o      (y_w),
    .sample_o (sample_w)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q      <= in_data_i.sample_in;
      ch_q     <= in_data_i.channel_in;
      bypass_q <= !(32'(in_data_i.channel_in) < CHANNELS);
    end
    if (ctrl.out_we) begin
      out_ch_q <= ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_we) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hx1_q[i] <= '0;
        hx2_q[i] <= '0;
        hy1_q[i] <= '0;
        hy2_q[i] <= '0;
      end
    end else if (ctrl.y_en && in_range) begin
      hx2_q[idx] <= hx1_q[idx];
      hx1_q[idx] <= x_q;
      hy2_q[idx] <= hy1_q[idx];
      hy1_q[idx] <= y_w;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_data_o.sample_out  = sample_w;
  assign out_data_o.channel_out = out_ch_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("sequencer still idle after accepting a word");

  a_no_history_on_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.y_en |-> !bypass_q)
    else $error("history written for a channel out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_we |-> !(out_valid_q && !out_ready_i))
    else $error("output word overwritten before it was taken");
`endif

endmodule
